[hw/rtl/glyph_rle_delta_decoder_top_macros.svh]
// Assertion macros used by the decoder's back stage.
`ifndef GLYPH_RLE_DELTA_DECODER_TOP_MACROS_SVH
`define GLYPH_RLE_DELTA_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GRD_ASSERT_IMPL(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
		else $error("decoder assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GRD_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
		else $error("decoder assertion failed");

`endif

[hw/rtl/grd_pkg.sv]
`default_nettype none

package grd_pkg;

	// Byte code layout
	localparam int LIT_BIT    = 7;
	localparam int VALUED_BIT = 6;
	localparam int RUN_W      = 6;
	localparam int PIX7_W     = 7;
	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 7;
	localparam int CFG_IDX_W  = 2;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GLYPH_WIDTH  = 2'd0,
		CFG_GLYPH_HEIGHT = 2'd1,
		CFG_DELTA_MODE   = 2'd2
	} grd_cfg_idx_t;

	// One classified run: count pixels of value, last_byte marks end of stream
	typedef struct packed {
		logic [RUN_W-1:0]  count;
		logic [PIX7_W-1:0] value;
		logic              last_byte;
	} grd_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/glyph_rle_delta_decoder_top.sv]
`default_nettype none

// Glyph bitmap decoder: takes a glyph's compressed stream one byte word at a
// time and returns its pixels in raster order, one result word per pixel, with
// glyph_done on the last one; a stream that ends before the bitmap is full
// closes with an end marker word (pixel_valid 0, glyph_done 1, truncated 1).
// A front stage classifies each byte word in the cycle it is accepted (literal,
// zero run, or valued run whose value is the next word) and pushes a run
// command into a four-entry queue; the back stage pops one command per cycle
// while idle, then steps each pixel through a read state, which reads the line
// store entry of the pixel above, and a pixel state, which sums, writes back
// and loads the output register, waiting while the output slot is stalled.
// The line store read-then-write loop finishes one pixel before the next
// starts. Width and height outside 1..MAX are clamped. Write the registers
// only while the decoder is idle; cfg_ready is always high.

module glyph_rle_delta_decoder_top #(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// compressed byte channel
	input  wire logic                            byte_valid,
	output logic                                 byte_stall,
	input  wire logic [grd_pkg::PIX_W-1:0]       code_byte,
	input  wire logic                            final_byte,
	// pixel result channel
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output logic [grd_pkg::PIX_W-1:0]            pixel_value,
	output logic                                 pixel_valid,
	output logic                                 glyph_done,
	output logic                                 truncated,
	// register write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [grd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [grd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1);
	localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1);

	logic [grd_pkg::CFG_DATA_W-1:0] glyph_width_q;
	logic [grd_pkg::CFG_DATA_W-1:0] glyph_height_q;
	logic                           delta_mode_q;
	logic [WW-1:0]                  width_eff;
	logic [HW-1:0]                  height_eff;

	logic                           push;
	grd_pkg::grd_cmd_t              push_cmd;
	grd_pkg::grd_cmd_t              head_cmd;
	logic                           queue_full;
	logic                           queue_empty;
	logic                           pop;

	assign cfg_ready  = 1'b1;
	assign byte_stall = queue_full;

	// Register file: taken on every valid write word, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_width_q  <= grd_pkg::CFG_DATA_W'(1);
			glyph_height_q <= grd_pkg::CFG_DATA_W'(1);
			delta_mode_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (grd_pkg::grd_cfg_idx_t'(cfg_index))
				grd_pkg::CFG_GLYPH_WIDTH:  glyph_width_q  <= cfg_data;
				grd_pkg::CFG_GLYPH_HEIGHT: glyph_height_q <= cfg_data;
				grd_pkg::CFG_DELTA_MODE:   delta_mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp dimensions: zero acts as one, anything past the maximum as the maximum
	always_comb begin
		priority if (glyph_width_q == '0) begin
			width_eff = WW'(1);
		end else if (int'(glyph_width_q) > MAX_GLYPH_WIDTH) begin
			width_eff = WW'(MAX_GLYPH_WIDTH);
		end else begin
			width_eff = WW'(glyph_width_q);
		end
		priority if (glyph_height_q == '0) begin
			height_eff = HW'(1);
		end else if (int'(glyph_height_q) > MAX_GLYPH_HEIGHT) begin
			height_eff = HW'(MAX_GLYPH_HEIGHT);
		end else begin
			height_eff = HW'(glyph_height_q);
		end
	end

	grd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.queue_full(queue_full),
		.code_byte (code_byte),
		.final_byte(final_byte),
		.push      (push),
		.cmd       (push_cmd)
	);

	grd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head_cmd(head_cmd),
		.full    (queue_full),
		.empty   (queue_empty)
	);

	grd_back #(
		.MAX_GLYPH_WIDTH (MAX_GLYPH_WIDTH),
		.MAX_GLYPH_HEIGHT(MAX_GLYPH_HEIGHT)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.head_cmd    (head_cmd),
		.pop         (pop),
		.width_eff   (width_eff),
		.height_eff  (height_eff),
		.delta_mode  (delta_mode_q),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.pixel_value (pixel_value),
		.pixel_valid (pixel_valid),
		.glyph_done  (glyph_done),
		.truncated   (truncated)
	);

endmodule

`default_nettype wire

[hw/rtl/grd_ram.sv]
`default_nettype none

module grd_ram #(
	parameter int WIDTH = 7,
	parameter int DEPTH = 64
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic                                     re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/grd_front.sv]
`default_nettype none

module grd_front (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    byte_valid,
	input  wire logic                    queue_full,
	input  wire logic [grd_pkg::PIX_W-1:0] code_byte,
	input  wire logic                    final_byte,
	output logic                         push,
	output grd_pkg::grd_cmd_t            cmd
);

	logic                        awaiting_q;
	logic [grd_pkg::RUN_W-1:0]   held_q;
	logic                        accept;

	assign accept = byte_valid && !queue_full;

	// Classify the word; a valued-run opener is held until its value arrives
	always_comb begin
		push          = 1'b0;
		cmd.count     = '0;
		cmd.value     = '0;
		cmd.last_byte = final_byte;
		if (accept) begin
			priority if (awaiting_q) begin
				push      = 1'b1;
				cmd.count = held_q;
				cmd.value = code_byte[grd_pkg::PIX7_W-1:0];
			end else if (code_byte[grd_pkg::LIT_BIT]) begin
				push      = 1'b1;
				cmd.count = grd_pkg::RUN_W'(1);
				cmd.value = code_byte[grd_pkg::PIX7_W-1:0];
			end else if (code_byte[grd_pkg::VALUED_BIT]) begin
				// opener on the last word: no pixels, end marker only
				push = final_byte;
			end else begin
				push      = 1'b1;
				cmd.count = code_byte[grd_pkg::RUN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b0;
			held_q     <= '0;
		end else if (accept) begin
			if (final_byte) begin
				awaiting_q <= 1'b0;
				held_q     <= '0;
			end else if (awaiting_q) begin
				awaiting_q <= 1'b0;
				held_q     <= '0;
			end else if (!code_byte[grd_pkg::LIT_BIT] && code_byte[grd_pkg::VALUED_BIT]) begin
				awaiting_q <= 1'b1;
				held_q     <= code_byte[grd_pkg::RUN_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/grd_queue.sv]
`default_nettype none

module grd_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire grd_pkg::grd_cmd_t  push_cmd,
	input  wire logic               pop,
	output grd_pkg::grd_cmd_t       head_cmd,
	output logic                    full,
	output logic                    empty
);

	grd_pkg::grd_cmd_t                slot_q [grd_pkg::QUEUE_DEPTH];
	logic [grd_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [grd_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [grd_pkg::QUEUE_AW:0]       count_q;
	logic                             do_push;
	logic                             do_pop;

	assign full     = (count_q == (grd_pkg::QUEUE_AW + 1)'(grd_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_cmd = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + grd_pkg::QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + grd_pkg::QUEUE_AW'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (grd_pkg::QUEUE_AW + 1)'(1);
				2'b01:   count_q <= count_q - (grd_pkg::QUEUE_AW + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/grd_back.sv]
`default_nettype none

`include "glyph_rle_delta_decoder_top_macros.svh"

module grd_back #(
	parameter int MAX_GLYPH_WIDTH  = 64,
	parameter int MAX_GLYPH_HEIGHT = 64,
	localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1),
	localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1),
	localparam int PW = $clog2(MAX_GLYPH_WIDTH * MAX_GLYPH_HEIGHT + 1),
	localparam int CW = (MAX_GLYPH_WIDTH > 1) ? $clog2(MAX_GLYPH_WIDTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       queue_empty,
	input  wire grd_pkg::grd_cmd_t          head_cmd,
	output logic                            pop,
	input  wire logic [WW-1:0]              width_eff,
	input  wire logic [HW-1:0]              height_eff,
	input  wire logic                       delta_mode,
	input  wire logic                       result_stall,
	output logic                            result_valid,
	output logic [grd_pkg::PIX_W-1:0]       pixel_value,
	output logic                            pixel_valid,
	output logic                            glyph_done,
	output logic                            truncated
);

	typedef enum logic [1:0] {S_IDLE, S_READ, S_PIX, S_TAIL} state_t;

	state_t                        state_q;
	logic [PW-1:0]                 pixel_index_q;
	logic [CW-1:0]                 col_q;
	logic [grd_pkg::PIX7_W-1:0]    running_q;
	logic [grd_pkg::RUN_W-1:0]     count_q;
	logic [grd_pkg::PIX7_W-1:0]    value_q;
	logic                          last_q;
	logic                          out_valid_q;
	logic [grd_pkg::PIX_W-1:0]     pixel_value_q;
	logic                          pixel_valid_q;
	logic                          glyph_done_q;
	logic                          truncated_q;

	logic [PW-1:0]                 size;
	logic                          full;
	logic                          slot_free;
	logic [CW-1:0]                 col_eff;
	logic [WW-1:0]                 col_inc;
	logic [CW-1:0]                 col_next;
	logic [grd_pkg::PIX7_W-1:0]    above_rd;
	logic [grd_pkg::PIX7_W-1:0]    above;
	logic [grd_pkg::PIX7_W-1:0]    delta_sum;
	logic [grd_pkg::PIX7_W-1:0]    run_next;
	logic [grd_pkg::PIX7_W-1:0]    pix7;
	logic [PW-1:0]                 pix_next;
	logic                          ram_we;

	assign size      = PW'(width_eff) * PW'(height_eff);
	assign full      = (pixel_index_q >= size);
	assign slot_free = !out_valid_q || !result_stall;
	assign pop       = (state_q == S_IDLE) && !queue_empty;

	// Wrap a column left beyond a narrowed row, then step to the next one
	assign col_eff  = (WW'(col_q) >= width_eff) ? '0 : col_q;
	assign col_inc  = WW'(col_eff) + WW'(1);
	assign col_next = (col_inc >= width_eff) ? '0 : col_inc[CW-1:0];

	// First row has nothing above it
	assign above     = (pixel_index_q >= PW'(width_eff)) ? above_rd : '0;
	assign delta_sum = value_q + above;
	assign run_next  = running_q + delta_sum;
	assign pix7      = delta_mode ? run_next : value_q;
	assign pix_next  = pixel_index_q + PW'(1);
	assign ram_we    = (state_q == S_PIX) && slot_free && delta_mode;

	grd_ram #(
		.WIDTH(grd_pkg::PIX7_W),
		.DEPTH(MAX_GLYPH_WIDTH)
	) u_line_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_eff),
		.wdata(delta_sum),
		.re   (state_q == S_READ),
		.raddr(col_eff),
		.rdata(above_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pixel_index_q <= '0;
			col_q         <= '0;
			running_q     <= '0;
			count_q       <= '0;
			value_q       <= '0;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			pixel_value_q <= '0;
			pixel_valid_q <= 1'b0;
			glyph_done_q  <= 1'b0;
			truncated_q   <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (!queue_empty) begin
						count_q <= head_cmd.count;
						value_q <= head_cmd.value;
						last_q  <= head_cmd.last_byte;
						if (full) begin
							// drop words past a full bitmap; the last one restarts
							if (head_cmd.last_byte) begin
								pixel_index_q <= '0;
								col_q         <= '0;
								running_q     <= '0;
							end
						end else if (head_cmd.count == '0) begin
							if (head_cmd.last_byte) begin
								state_q <= S_TAIL;
							end
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_PIX;
				end
				S_PIX: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						pixel_value_q <= {pix7, pix7[grd_pkg::PIX7_W-1]};
						pixel_valid_q <= 1'b1;
						glyph_done_q  <= (pix_next == size);
						truncated_q   <= 1'b0;
						pixel_index_q <= pix_next;
						col_q         <= col_next;
						count_q       <= count_q - grd_pkg::RUN_W'(1);
						if (delta_mode) begin
							running_q <= run_next;
						end
						if (pix_next == size) begin
							state_q <= S_IDLE;
							if (last_q) begin
								pixel_index_q <= '0;
								col_q         <= '0;
								running_q     <= '0;
							end
						end else if (count_q == grd_pkg::RUN_W'(1)) begin
							state_q <= last_q ? S_TAIL : S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_TAIL: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						pixel_value_q <= '0;
						pixel_valid_q <= 1'b0;
						glyph_done_q  <= 1'b1;
						truncated_q   <= 1'b1;
						pixel_index_q <= '0;
						col_q         <= '0;
						running_q     <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid = out_valid_q;
	assign pixel_value  = pixel_value_q;
	assign pixel_valid  = pixel_valid_q;
	assign glyph_done   = glyph_done_q;
	assign truncated    = truncated_q;

	`GRD_ASSERT_IMPL(a_pix_in_bitmap, clk, arst_n, state_q == S_PIX, pixel_index_q < size)
	`GRD_ASSERT_IMPL(a_marker_flags, clk, arst_n, out_valid_q && !pixel_valid_q, glyph_done_q && truncated_q && pixel_value_q == '0)
	`GRD_ASSERT_NEXT(a_pix_loads_out, clk, arst_n, state_q == S_PIX && slot_free, out_valid_q && pixel_valid_q)

endmodule

`default_nettype wire

[dv/tb_glyph_rle_delta_decoder_top.sv]
`timescale 1ns / 1ps

module tb_glyph_rle_delta_decoder_top;
	import grd_pkg::*;

	localparam int MAX_W         = 64;
	localparam int MAX_H         = 64;
	localparam int RANDOM_WORDS  = 430;
	// Covers the queued zero-pixel commands and the back stage draining.
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int HOLD_CYCLES   = 600;

	// One compressed byte word as offered on the input channel.
	typedef struct packed {
		logic [PIX_W-1:0] code;
		logic             last;
	} code_word_t;

	// One result word as seen on the output channel.
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic             valid;
		logic             done;
		logic             trunc;
	} pixel_word_t;

	typedef struct packed {
		grd_cfg_idx_t          idx;
		logic [CFG_DATA_W-1:0] data;
	} reg_write_t;

	// Shapes of generated glyph streams.
	typedef enum int {
		GLYPH_EXACT,  // ends on the byte that fills the bitmap
		GLYPH_SHORT,  // ends before the bitmap is full
		GLYPH_LONG,   // fills early, then trailing bytes up to the final one
		GLYPH_NOISE   // random bytes, final on the last
	} glyph_kind_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  byte_valid   = 1'b0;
	logic                  byte_stall;
	logic [PIX_W-1:0]      code_byte    = '0;
	logic                  final_byte   = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [PIX_W-1:0]      pixel_value;
	logic                  pixel_valid;
	logic                  glyph_done;
	logic                  truncated;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	grd_cfg_idx_t          cfg_index    = CFG_GLYPH_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Stimulus and expectation stores.
	code_word_t  code_words[$];
	reg_write_t  reg_writes[$];
	pixel_word_t pixels_due[$];

	int words_queued   = 0;
	int words_taken    = 0;
	int writes_queued  = 0;
	int writes_taken   = 0;
	int random_words   = 0;
	int glyphs_sent    = 0;
	int pixels_seen    = 0;
	int markers_seen   = 0;
	int bad_words      = 0;
	int plan_size      = 1;
	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int holds_asked    = 0;
	int holds_given    = 0;
	int hold_left      = 0;
	int cycles         = 0;

	// Decoder state as the testbench sees it, starting from reset.
	logic [CFG_DATA_W-1:0] width_reg  = 7'd1;
	logic [CFG_DATA_W-1:0] height_reg = 7'd1;
	logic                  delta_reg  = 1'b0;
	logic [PIX7_W-1:0]     line_above [MAX_W];
	logic [PIX7_W-1:0]     hsum       = '0;
	int                    pix_pos    = 0;
	int                    col_pos    = 0;
	int                    held_count = 0;
	logic                  want_value = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	glyph_rle_delta_decoder_top #(
		.MAX_GLYPH_WIDTH (MAX_W),
		.MAX_GLYPH_HEIGHT(MAX_H)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.code_byte   (code_byte),
		.final_byte  (final_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pixel_value (pixel_value),
		.pixel_valid (pixel_valid),
		.glyph_done  (glyph_done),
		.truncated   (truncated),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Width and height of 0 act as 1, anything above the maximum as the maximum.
	function automatic int clamp_dim(input logic [CFG_DATA_W-1:0] v, input int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return int'(v);
	endfunction

	// Drop all per-glyph state; the line store survives.
	task automatic restart_glyph();
		hsum = '0;
		pix_pos = 0;
		col_pos = 0;
		want_value = 1'b0;
		held_count = 0;
	endtask

	task automatic apply_register(input grd_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_GLYPH_WIDTH: begin
				width_reg = data;
			end
			CFG_GLYPH_HEIGHT: begin
				height_reg = data;
			end
			CFG_DELTA_MODE: begin
				delta_reg = data[0];
			end
			default: begin
			end
		endcase
	endtask

	// Decode one raw 7-bit value into a pixel word and advance the raster position.
	task automatic emit_pixel(input logic [PIX7_W-1:0] raw, input int width, input int size);
		logic [PIX7_W-1:0] v;
		pixel_word_t       w;
		if (col_pos >= width)
			col_pos = 0;
		if (delta_reg) begin
			// Add the pixel above (nothing on the first row), then the running sum.
			v = raw + ((pix_pos >= width) ? line_above[col_pos] : 7'd0);
			line_above[col_pos] = v;
			hsum = hsum + v;
			v = hsum;
		end else begin
			v = raw;
		end
		pix_pos++;
		col_pos++;
		if (col_pos >= width)
			col_pos = 0;
		w.value = {v, v[PIX7_W-1]};
		w.valid = 1'b1;
		w.done  = (pix_pos >= size);
		w.trunc = 1'b0;
		pixels_due.push_back(w);
	endtask

	// Work out every result word that one accepted byte word causes.
	task automatic decode_code_byte(input code_word_t cw);
		int                width;
		int                height;
		int                size;
		int                count;
		logic [PIX7_W-1:0] value;
		bit                has_run;
		width   = clamp_dim(width_reg, MAX_W);
		height  = clamp_dim(height_reg, MAX_H);
		size    = width * height;
		count   = 0;
		value   = '0;
		has_run = 1'b0;
		// Bitmap already full: ignore, but the final byte still restarts.
		if (pix_pos >= size) begin
			if (cw.last)
				restart_glyph();
			return;
		end
		if (want_value) begin
			want_value = 1'b0;
			count      = held_count;
			held_count = 0;
			value      = cw.code[PIX7_W-1:0];
			has_run    = 1'b1;
		end else if (cw.code[LIT_BIT]) begin
			count   = 1;
			value   = cw.code[PIX7_W-1:0];
			has_run = 1'b1;
		end else if (cw.code[VALUED_BIT]) begin
			held_count = int'(cw.code[RUN_W-1:0]);
			want_value = 1'b1;
		end else begin
			count   = int'(cw.code[RUN_W-1:0]);
			has_run = 1'b1;
		end
		// Runs are cut at the end of the bitmap.
		if (has_run) begin
			while (count > 0 && pix_pos < size) begin
				emit_pixel(value, width, size);
				count--;
			end
		end
		if (pix_pos >= size) begin
			if (cw.last)
				restart_glyph();
		end else if (cw.last) begin
			// Stream ended short: close with an end marker.
			pixels_due.push_back('{value: '0, valid: 1'b0, done: 1'b1, trunc: 1'b1});
			restart_glyph();
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers, called from the sequence below between edges
	// ------------------------------------------------------------------

	task automatic send_word(input logic [PIX_W-1:0] code, input logic last);
		code_words.push_back('{code: code, last: last});
		words_queued++;
	endtask

	// Queue all three registers and hold until the channel has taken them.
	task automatic write_regs(input int w, input int h, input int d);
		reg_writes.push_back('{idx: CFG_GLYPH_WIDTH, data: w[CFG_DATA_W-1:0]});
		reg_writes.push_back('{idx: CFG_GLYPH_HEIGHT, data: h[CFG_DATA_W-1:0]});
		reg_writes.push_back('{idx: CFG_DELTA_MODE, data: d[CFG_DATA_W-1:0]});
		writes_queued += 3;
		plan_size = clamp_dim(w[CFG_DATA_W-1:0], MAX_W) * clamp_dim(h[CFG_DATA_W-1:0], MAX_H);
		while (writes_taken != writes_queued)
			@(negedge clk);
	endtask

	// Hold until every word is taken and every result is back, then let the block settle.
	task automatic wait_drained();
		while (words_taken != words_queued || pixels_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Mostly well-formed glyphs, the rest broken or noise.
	function automatic glyph_kind_t random_kind();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return GLYPH_EXACT;
		if (roll < 75)
			return GLYPH_SHORT;
		if (roll < 85)
			return GLYPH_LONG;
		return GLYPH_NOISE;
	endfunction

	// Build one glyph stream for the current bitmap size and queue it.
	task automatic queue_glyph(input glyph_kind_t kind);
		int               left;
		int               stop_at;
		int               len;
		int               pick;
		int               lit_pct;
		int               extra;
		bit               big;
		logic             fin;
		logic [PIX_W-1:0] code;
		glyphs_sent++;
		if (kind == GLYPH_NOISE) begin
			extra = $urandom_range(1, 10);
			for (int i = 0; i < extra; i++) begin
				code = PIX_W'($urandom);
				send_word(code, i == extra - 1);
			end
			random_words += extra;
			return;
		end
		left    = plan_size;
		big     = plan_size > 256;
		lit_pct = big ? 5 : 40;
		stop_at = (kind == GLYPH_SHORT) ? $urandom_range(1, plan_size) : 0;
		while (left > stop_at) begin
			pick = $urandom_range(99);
			if (pick < lit_pct)
				len = 1;
			else if (big)
				len = $urandom_range(40, 63);
			else if ($urandom_range(4) == 0)
				len = $urandom_range(0, 63);
			else
				len = $urandom_range(0, (left < 8) ? left : 8);
			left = (len >= left) ? 0 : left - len;
			fin  = (kind == GLYPH_EXACT) && (left == 0);
			code = PIX_W'($urandom);
			if (pick < lit_pct) begin
				code[LIT_BIT] = 1'b1;
				send_word(code, fin);
				random_words++;
			end else if (pick < 70) begin
				code = {2'b00, len[RUN_W-1:0]};
				send_word(code, fin);
				random_words++;
			end else begin
				code = {2'b01, len[RUN_W-1:0]};
				send_word(code, 1'b0);
				code = PIX_W'($urandom);
				send_word(code, fin);
				random_words += 2;
			end
		end
		if (kind == GLYPH_SHORT) begin
			// End on a literal, or on a valued run header that never gets its value.
			code = PIX_W'($urandom);
			if ($urandom_range(1) != 0)
				code[LIT_BIT:VALUED_BIT] = 2'b01;
			else
				code[LIT_BIT] = 1'b1;
			send_word(code, 1'b1);
			random_words++;
		end else if (kind == GLYPH_LONG) begin
			// Trailing bytes past a full bitmap are ignored and not counted.
			extra = $urandom_range(1, 4);
			for (int i = 0; i < extra; i++) begin
				code = PIX_W'($urandom);
				send_word(code, i == extra - 1);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Channel processes
	// ------------------------------------------------------------------

	// Byte word driver: predict on acceptance, then advance or hold the offer.
	always @(posedge clk) begin
		code_word_t nxt;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				decode_code_byte('{code: code_byte, last: final_byte});
				words_taken++;
			end
			// Only touch the offer when the slot is free; a stalled word stays put.
			if (!byte_valid || !byte_stall) begin
				if (code_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					nxt = code_words.pop_front();
					byte_valid <= 1'b1;
					code_byte  <= nxt.code;
					final_byte <= nxt.last;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// Register write driver: update the predicted registers as each write lands.
	always @(posedge clk) begin
		reg_write_t nxt;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				apply_register(cfg_index, cfg_data);
				writes_taken++;
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					nxt = reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= nxt.idx;
					cfg_data  <= nxt.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off: counted here, requested by the sequence.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (holds_given != holds_asked) begin
			hold_left   <= HOLD_CYCLES;
			holds_given <= holds_given + 1;
		end
	end

	// Result monitor: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		pixel_word_t seen;
		pixel_word_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				seen = '{value: pixel_value, valid: pixel_valid, done: glyph_done,
					trunc: truncated};
				if (seen.valid)
					pixels_seen++;
				else
					markers_seen++;
				if (pixels_due.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("unexpected result word: value %02h valid %0b done %0b truncated %0b",
							seen.value, seen.valid, seen.done, seen.trunc);
				end else begin
					want = pixels_due.pop_front();
					if (seen !== want) begin
						bad_words++;
						if (bad_words <= 10)
							$display("result mismatch: expected value %02h valid %0b done %0b truncated %0b, got value %02h valid %0b done %0b truncated %0b",
								want.value, want.valid, want.done, want.trunc,
								seen.value, seen.valid, seen.done, seen.trunc);
					end
				end
			end
			result_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d result words still due", cycles,
				pixels_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		int phase;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset dimensions, 1x1 plain: brightest literal fills the bitmap on the
		// final byte; a zero-length run and a dangling valued header each end short.
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b1);
		send_word(8'h41, 1'b1);
		wait_drained();

		// 4x2 plain: darkest literal, zero-length valued run eating its value byte,
		// a maximal zero run cut at the bitmap end, then ignored bytes to the final.
		write_regs(4, 2, 0);
		send_word(8'h80, 1'b0);
		send_word(8'h40, 1'b0);
		send_word(8'hAB, 1'b0);
		send_word(8'h3F, 1'b0);
		send_word(8'h85, 1'b0);
		send_word(8'h81, 1'b1);
		wait_drained();

		// 3x3 delta: two valued runs feed the line store across rows;
		// the final literal fills the bitmap exactly.
		write_regs(3, 3, 1);
		send_word(8'h43, 1'b0);
		send_word(8'h7F, 1'b0);
		send_word(8'h45, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h90, 1'b1);
		wait_drained();

		// Width 0 acts as 1, height 127 as the maximum: one tall delta column.
		write_regs(0, 127, 1);
		send_word(8'h7F, 1'b0);
		send_word(8'h05, 1'b0);
		send_word(8'h01, 1'b1);
		wait_drained();

		// Width 127 acts as the maximum, height 0 as 1: a pixel, then the end marker.
		write_regs(127, 0, 0);
		send_word(8'hC0, 1'b1);
		wait_drained();

		// Random glyphs, rotating through the idling mixes.
		phase = 0;
		while (random_words < RANDOM_WORDS) begin
			case (phase % 4)
				0: begin
					send_gap_pct   = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_gap_pct   = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct   = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_gap_pct   = 16;
					recv_stall_pct = 16;
				end
			endcase
			if (phase == 3)
				write_regs(64, 64, 1);
			else if (phase == 8)
				write_regs(127, 5, $urandom_range(1));
			else
				write_regs($urandom_range(1, 12), $urandom_range(1, 6), $urandom_range(1));
			if (phase == 3 || phase == 8) begin
				queue_glyph(GLYPH_EXACT);
			end else begin
				repeat ($urandom_range(3, 6))
					queue_glyph(random_kind());
			end
			// Stall the output for a long stretch while words keep coming, so the
			// command queue fills and the input backs up.
			if (phase == 0)
				holds_asked++;
			// Pause the sender until everything is back, then resume the phase.
			if (phase % 2 == 1) begin
				wait_drained();
				repeat (2)
					queue_glyph(random_kind());
			end
			wait_drained();
			phase++;
		end

		$display("covered %0d glyphs in %0d phases: %0d byte words, %0d register writes",
			glyphs_sent, phase, words_taken, writes_taken);
		$display("checked %0d pixels and %0d end markers, %0d mismatching words",
			pixels_seen, markers_seen, bad_words);
		if (bad_words == 0 && pixels_due.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
